@@ src/stfs_pkg.sv @@
// Shared types, widths, codes and the microcode store for the sorted time floor search.
// No dependencies; every other file of the block but stfs_ram imports this package.
package stfs_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths of the beats
    localparam int CMD_W     = 2;
    localparam int TIME_W    = 31;
    localparam int PAY_W     = 32;
    localparam int STAT_W    = 2;
    localparam int OUT_IDX_W = 10;

    // Command and status codes
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Datapath operations, one per microcode step
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_CLEAR,
        OP_APPEND,
        OP_Q_INIT,
        OP_ISSUE_LAST,
        OP_SET_LAST,
        OP_ISSUE_MID,
        OP_NARROW,
        OP_READ_PAY,
        OP_TAKE_PAY,
        OP_EMIT
    } t_op;

    // Branch conditions of the sequencer
    typedef enum logic [3:0] {
        C_NEXT,
        C_JUMP,
        C_DISPATCH,
        C_EMPTY,
        C_ONE,
        C_KEY_LE,
        C_KEY_GE,
        C_SPAN_DONE,
        C_EMIT
    } t_cond;

    // Step addresses of the microprogram
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step STEP_FETCH   = 4'd0;
    localparam t_step STEP_CLEAR   = 4'd1;
    localparam t_step STEP_APPEND  = 4'd2;
    localparam t_step STEP_Q_INIT  = 4'd3;
    localparam t_step STEP_Q_ONE   = 4'd4;
    localparam t_step STEP_Q_FIRST = 4'd5;
    localparam t_step STEP_Q_LAST  = 4'd6;
    localparam t_step STEP_LOOP    = 4'd7;
    localparam t_step STEP_CMP     = 4'd8;
    localparam t_step STEP_RD_PAY  = 4'd9;
    localparam t_step STEP_PAY     = 4'd10;
    localparam t_step STEP_EMIT    = 4'd11;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic in_fire;
        t_cmd cmd;
        logic empty;
        logic one;
        logic key_le;
        logic key_ge;
        logic span_done;
        logic out_free;
    } t_flags;

    // Microprogram: a failed condition falls through to the next step, but dispatch and emit wait on the same step
    function automatic t_uword uc_rom(input t_step step);
        t_uword w;
        unique case (step)
            STEP_FETCH:   w = '{OP_LATCH,      C_DISPATCH,  STEP_FETCH};
            STEP_CLEAR:   w = '{OP_CLEAR,      C_JUMP,      STEP_EMIT};
            STEP_APPEND:  w = '{OP_APPEND,     C_JUMP,      STEP_EMIT};
            STEP_Q_INIT:  w = '{OP_Q_INIT,     C_EMPTY,     STEP_EMIT};
            STEP_Q_ONE:   w = '{OP_NONE,       C_ONE,       STEP_RD_PAY};
            STEP_Q_FIRST: w = '{OP_ISSUE_LAST, C_KEY_LE,    STEP_RD_PAY};
            STEP_Q_LAST:  w = '{OP_SET_LAST,   C_KEY_GE,    STEP_RD_PAY};
            STEP_LOOP:    w = '{OP_ISSUE_MID,  C_SPAN_DONE, STEP_RD_PAY};
            STEP_CMP:     w = '{OP_NARROW,     C_JUMP,      STEP_LOOP};
            STEP_RD_PAY:  w = '{OP_READ_PAY,   C_NEXT,      STEP_FETCH};
            STEP_PAY:     w = '{OP_TAKE_PAY,   C_NEXT,      STEP_FETCH};
            STEP_EMIT:    w = '{OP_EMIT,       C_EMIT,      STEP_FETCH};
            default:      w = '{OP_NONE,       C_JUMP,      STEP_FETCH};
        endcase
        return w;
    endfunction

    // Entry step for each command
    function automatic t_step uc_dispatch(input t_cmd cmd);
        t_step s;
        unique case (cmd)
            CMD_CLEAR:  s = STEP_CLEAR;
            CMD_APPEND: s = STEP_APPEND;
            CMD_QUERY:  s = STEP_Q_INIT;
            CMD_NOP:    s = STEP_EMIT;
            default:    s = STEP_EMIT;
        endcase
        return s;
    endfunction

endpackage

@@ src/stfs_if.sv @@
// Handshake channels of the block: command beats in, result beats out.
// Depends on stfs_pkg for field widths.
interface stfs_in_if import stfs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [TIME_W-1:0] entry_time;
    logic [PAY_W-1:0]  entry_payload;

    modport source (output valid, command, entry_time, entry_payload, input ready);
    modport sink   (input valid, command, entry_time, entry_payload, output ready);
endinterface

interface stfs_out_if import stfs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STAT_W-1:0]    status;
    logic [OUT_IDX_W-1:0] found_index;
    logic [PAY_W-1:0]     found_payload;

    modport source (output valid, status, found_index, found_payload, input ready);
    modport sink   (input valid, status, found_index, found_payload, output ready);
endinterface

@@ src/sorted_time_floor_search_top.sv @@
// Command path: a no-op goes straight to the result step; clear, append and a query on an empty
// table pass through their own step first; other queries are settled by the single-entry or
// edge checks, or else by a binary search of up to ten probes at 1024 entries, each a read and
// a compare on the single registered read port of the time memory.
// Throughput: one command in work; the next is accepted at the edge after its result is loaded,
// even while it waits. Reset clears the count, step and result valid; no clearing pass runs.
module sorted_time_floor_search_top import stfs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    stfs_in_if.sink    i_in,
    stfs_out_if.source o_out
);

    t_op    w_op;
    t_flags w_flags;

    stfs_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_op    (w_op)
    );

    stfs_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_op),
        .o_flags (w_flags),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

@@ src/stfs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, and register the read word; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/stfs_useq.sv @@
// Microcode sequencer: step counter, control store lookup and branch logic.
// Depends on stfs_pkg for the control word, flags and microprogram.
module stfs_useq import stfs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_op    o_op
);

    t_step  r_step;
    t_step  n_step;
    t_uword w_word;

    assign w_word = uc_rom(r_step);
    assign o_op   = w_word.op;

    // Pick the next step from the branch condition of the current word
    always_comb begin
        unique case (w_word.cond)
            C_NEXT:      n_step = r_step + t_step'(1);
            C_JUMP:      n_step = w_word.target;
            C_DISPATCH:  n_step = i_flags.in_fire ? uc_dispatch(i_flags.cmd) : r_step;
            C_EMPTY:     n_step = i_flags.empty ? w_word.target : r_step + t_step'(1);
            C_ONE:       n_step = i_flags.one ? w_word.target : r_step + t_step'(1);
            C_KEY_LE:    n_step = i_flags.key_le ? w_word.target : r_step + t_step'(1);
            C_KEY_GE:    n_step = i_flags.key_ge ? w_word.target : r_step + t_step'(1);
            C_SPAN_DONE: n_step = i_flags.span_done ? w_word.target : r_step + t_step'(1);
            C_EMIT:      n_step = i_flags.out_free ? w_word.target : r_step;
            default:     n_step = STEP_FETCH;
        endcase
    end

    // Advance the step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

@@ src/stfs_dpath.sv @@
// Datapath: table memories, entry count, search bounds and the result register.
// Depends on stfs_pkg, stfs_if and stfs_ram; driven one operation a cycle by stfs_useq.
module stfs_dpath import stfs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_op    i_op,
    output t_flags o_flags,
    stfs_in_if.sink    i_in,
    stfs_out_if.source o_out
);

    logic [TIME_W-1:0] r_key;
    logic [PAY_W-1:0]  r_pay_in;
    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_lo;
    logic [IDX_W-1:0]  r_hi;
    logic [IDX_W-1:0]  r_mid;
    logic [IDX_W-1:0]  r_idx;
    t_status           r_status;
    logic [PAY_W-1:0]  r_res_pay;

    logic              r_o_valid;
    t_status           r_o_status;
    logic [IDX_W-1:0]  r_o_idx;
    logic [PAY_W-1:0]  r_o_pay;

    logic              w_in_fire;
    logic              w_out_free;
    logic              w_full;
    logic [IDX_W-1:0]  w_last;
    logic [IDX_W:0]    w_sum;
    logic [IDX_W-1:0]  w_mid;

    logic              w_t_we;
    logic              w_t_re;
    logic [IDX_W-1:0]  w_t_raddr;
    logic [TIME_W-1:0] w_t_rdata;
    logic              w_p_re;
    logic [PAY_W-1:0]  w_p_rdata;

    // Handshake and derived values
    assign i_in.ready = (i_op == OP_LATCH);
    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_out_free = !r_o_valid || o_out.ready;
    assign w_full     = (r_count == CNT_W'(TABLE_DEPTH));
    assign w_last     = IDX_W'(r_count - CNT_W'(1));
    assign w_sum      = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid      = w_sum[IDX_W:1];

    // Flags for the sequencer
    assign o_flags.in_fire   = w_in_fire;
    assign o_flags.cmd       = t_cmd'(i_in.command);
    assign o_flags.empty     = (r_count == '0);
    assign o_flags.one       = (r_count == CNT_W'(1));
    assign o_flags.key_le    = (r_key <= w_t_rdata);
    assign o_flags.key_ge    = (r_key >= w_t_rdata);
    assign o_flags.span_done = (r_lo >= r_hi);
    assign o_flags.out_free  = w_out_free;

    // Time memory read address per operation
    always_comb begin
        case (i_op)
            OP_Q_INIT:     w_t_raddr = '0;
            OP_ISSUE_LAST: w_t_raddr = w_last;
            default:       w_t_raddr = w_mid;
        endcase
    end

    assign w_t_re = (i_op == OP_Q_INIT) || (i_op == OP_ISSUE_LAST) || (i_op == OP_ISSUE_MID);
    assign w_t_we = (i_op == OP_APPEND) && !w_full;
    assign w_p_re = (i_op == OP_READ_PAY);

    stfs_ram #(.WIDTH(TIME_W), .DEPTH(TABLE_DEPTH)) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (w_t_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (r_key),
        .i_re    (w_t_re),
        .i_raddr (w_t_raddr),
        .o_rdata (w_t_rdata)
    );

    stfs_ram #(.WIDTH(PAY_W), .DEPTH(TABLE_DEPTH)) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (w_t_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (r_pay_in),
        .i_re    (w_p_re),
        .i_raddr (r_idx),
        .o_rdata (w_p_rdata)
    );

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_op == OP_CLEAR) begin
            r_count <= '0;
        end else if (w_t_we) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // Working registers of the current beat
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LATCH: begin
                if (w_in_fire) begin
                    r_key     <= i_in.entry_time;
                    r_pay_in  <= i_in.entry_payload;
                    r_status  <= ST_OK;
                    r_idx     <= '0;
                    r_res_pay <= '0;
                end
            end
            OP_APPEND: begin
                if (w_full) begin
                    r_status <= ST_FULL;
                end
            end
            OP_Q_INIT: begin
                r_status <= (r_count == '0) ? ST_EMPTY : ST_OK;
                r_lo     <= '0;
                r_hi     <= w_last;
            end
            OP_SET_LAST: begin
                r_idx <= w_last;
            end
            OP_ISSUE_MID: begin
                r_mid <= w_mid;
                r_idx <= r_lo - IDX_W'(1);
            end
            OP_NARROW: begin
                if (w_t_rdata > r_key) begin
                    r_hi <= r_mid;
                end else begin
                    r_lo <= r_mid + IDX_W'(1);
                end
            end
            OP_TAKE_PAY: begin
                r_res_pay <= w_p_rdata;
            end
            default: begin
            end
        endcase
    end

    // Result register: load when the previous beat has gone
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_op == OP_EMIT && w_out_free) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_EMIT && w_out_free) begin
            r_o_status <= r_status;
            r_o_idx    <= r_idx;
            r_o_pay    <= r_res_pay;
        end
    end

    assign o_out.valid         = r_o_valid;
    assign o_out.status        = r_o_status;
    assign o_out.found_index   = OUT_IDX_W'(r_o_idx);
    assign o_out.found_payload = r_o_pay;

endmodule

@@ src/stfs_checker.sv @@
// Port-level checks of the sorted time floor search, and the bind that attaches them.
// Depends on stfs_pkg for field widths; bound into sorted_time_floor_search_top.
module stfs_checker import stfs_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [STAT_W-1:0]    i_out_status,
    input logic [OUT_IDX_W-1:0] i_out_index,
    input logic [PAY_W-1:0]     i_out_payload
);

    logic       w_in_fire;
    logic       w_out_fire;
    logic [1:0] r_pending;

    assign w_in_fire  = i_in_valid && i_in_ready;
    assign w_out_fire = i_out_valid && i_out_ready;

    // Track beats taken in but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 2'(w_in_fire) - 2'(w_out_fire);
        end
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_status)
            && $stable(i_out_index) && $stable(i_out_payload))
        else $error("result beat changed while stalled");

    // No result without a command behind it
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_fire |-> r_pending != 2'd0)
        else $error("result beat without an outstanding command");

    // At most one command in work besides one waiting result
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |-> r_pending < 2'd2)
        else $error("command taken with two beats outstanding");

    // Reset drops the result register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind sorted_time_floor_search_top stfs_checker u_stfs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_status  (o_out.status),
    .i_out_index   (o_out.found_index),
    .i_out_payload (o_out.found_payload)
);
